// ----- src/p2rl_pkg.sv -----
package p2rl_pkg;

  // Fixed field widths of the item channels
  localparam int VERT_W  = 12;
  localparam int LABEL_W = 15;
  localparam int OUT_CW  = 32;
  localparam int SLOT_W  = 3;

  // Commands
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_REFINE = 2'd2;

  // Local node positions of the six-node triangle
  localparam logic [SLOT_W-1:0] SLOT_C0  = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_M01 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_C1  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_M02 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_M12 = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_C2  = 3'd5;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_LOAD,
    S_SLOT,
    S_CORNER,
    S_EDGE_P,
    S_EDGE_Q,
    S_HASH,
    S_PROBE_RD,
    S_PROBE,
    S_EMIT
  } state_t;

  function automatic logic slot_is_edge(input logic [SLOT_W-1:0] s);
    return (s == SLOT_M01) || (s == SLOT_M02) || (s == SLOT_M12);
  endfunction

endpackage

// ----- src/p2rl_if.sv -----
// Input channel: one command transaction
interface p2rl_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic [p2rl_pkg::VERT_W-1:0] vertex_a;
  logic [p2rl_pkg::VERT_W-1:0] vertex_b;
  logic [p2rl_pkg::VERT_W-1:0] vertex_c;
  logic signed [31:0]          coord_x;
  logic signed [31:0]          coord_y;
  logic signed [31:0]          coord_z;

  modport source(output valid, command, vertex_a, vertex_b, vertex_c,
                 coord_x, coord_y, coord_z, input ready);
  modport sink(input valid, command, vertex_a, vertex_b, vertex_c,
               coord_x, coord_y, coord_z, output ready);
endinterface

// Result channel: one labeled node per transaction
interface p2rl_out_if;
  logic                         valid;
  logic                         ready;
  logic [p2rl_pkg::SLOT_W-1:0]  slot;
  logic [p2rl_pkg::LABEL_W-1:0] label;
  logic                         is_new;
  logic signed [31:0]           out_x;
  logic signed [31:0]           out_y;
  logic signed [31:0]           out_z;
  logic                         table_full;
  logic                         last;

  modport source(output valid, slot, label, is_new, out_x, out_y, out_z,
                 table_full, last, input ready);
  modport sink(input valid, slot, label, is_new, out_x, out_y, out_z,
               table_full, last, output ready);
endinterface

// ----- src/p2rl_ram.sv -----
module p2rl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/triangle_p2_refine_labeler.sv -----
// Linear-to-quadratic triangle labeler. Load node coordinates with command 1,
// then send triangles with command 2; each triangle returns six transactions
// (corner 0, mid 01, corner 1, mid 02, mid 12, corner 2) with first-seen
// labels and Q8.24 coordinates, midpoints rounded toward minus infinity.
// One item is handled at a time by a small sequencer over single-port-read
// memories. A load writes the node's coordinates; a triangle is accepted, then
// each corner reads its label map and each edge reads both end nodes, hashes
// and probes the edge table (linear probing), and each result waits until it is
// taken. Where MAX_EDGES is not a power of two each edge adds a hash remainder
// (reciprocal multiply, multiply-subtract, one correction); where MAX_NODES is
// below 4096 each node id of the transaction is first wrapped by the same
// remainder unit. After reset and after each clear command the block sweeps the
// label maps, one entry a cycle over max(MAX_NODES, MAX_EDGES) entries, and is
// not ready meanwhile.
module triangle_p2_refine_labeler #(
  parameter int MAX_NODES  = 4096,
  parameter int MAX_EDGES  = 16384,
  parameter int COORD_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  p2rl_in_if.sink    in_ch,
  p2rl_out_if.source out_ch
);
  import p2rl_pkg::*;

  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int EDGE_W  = $clog2(MAX_EDGES);
  localparam int KEY_W   = 1 + 2 * NODE_W;
  localparam int CMAP_W  = 1 + LABEL_W;
  localparam int HASH_W  = NODE_W + 5;
  localparam int REM_W   = (HASH_W > VERT_W) ? HASH_W : VERT_W;
  localparam int DIV_W   = ((EDGE_W > NODE_W) ? EDGE_W : NODE_W) + 1;
  localparam int SH_W    = REM_W + DIV_W;
  localparam int MB_W    = (REM_W > DIV_W) ? REM_W : DIV_W;
  localparam int MUL_W   = REM_W + MB_W;
  localparam int RCP_N   = (1 << REM_W) / MAX_NODES;
  localparam int RCP_E   = (1 << REM_W) / MAX_EDGES;
  localparam int K_W     = 2;
  localparam int LOAD_W  = (COORD_BITS < OUT_CW) ? COORD_BITS : OUT_CW;
  localparam int CLR_N   = (MAX_NODES > MAX_EDGES) ? MAX_NODES : MAX_EDGES;
  localparam int CLR_W   = $clog2(CLR_N);
  localparam bit NODE_MOD  = MAX_NODES < (1 << VERT_W);
  localparam bit EDGE_POW2 = (MAX_EDGES & (MAX_EDGES - 1)) == 0;

  state_t state_r, state_nxt;

  logic [1:0]            cmd_r;
  logic [VERT_W-1:0]     vb_r, vc_r;
  logic signed [31:0]    cx_r, cy_r, cz_r;
  logic [NODE_W-1:0]     a_r, b_r, c_r;
  logic [1:0]            red_r;
  logic [REM_W-1:0]      rem_r;
  logic [MUL_W-1:0]      prod_r;
  logic [K_W-1:0]        k_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [EDGE_W-1:0]     idx_r, pcnt_r;
  logic [NODE_W-1:0]     lo_r, hi_r;
  logic [COORD_BITS-1:0] px_r, py_r, pz_r;
  logic [LABEL_W-1:0]    next_label_r;
  logic [CLR_W-1:0]      clr_r;
  logic [LABEL_W-1:0]    o_label_r;
  logic                  o_new_r, o_full_r;
  logic signed [31:0]    o_x_r, o_y_r, o_z_r;

  // Memory ports
  logic [COORD_BITS-1:0] xr, yr, zr;
  logic                  crd_we;
  logic [NODE_W-1:0]     node_raddr;
  logic                  cm_we;
  logic [NODE_W-1:0]     cm_waddr;
  logic [CMAP_W-1:0]     cm_wdata, cm_rd;
  logic                  ek_we, el_we;
  logic [EDGE_W-1:0]     ek_waddr;
  logic [KEY_W-1:0]      ek_wdata, ek_rd;
  logic [LABEL_W-1:0]    el_rd;

  // Handshake and decode
  logic                  in_acc, out_acc, clr_end, is_edge, k_done;
  logic [NODE_W-1:0]     cn, pn, qn, lo_n, hi_n;
  logic [HASH_W-1:0]     hash_n;
  logic [DIV_W-1:0]      div_sel;
  logic [MB_W-1:0]       rcp_sel, mul_b;
  logic [REM_W-1:0]      mul_a, q_w;
  logic [MUL_W-1:0]      mul_p;
  logic [REM_W-1:0]      rem_step;
  logic                  hit, empty, last_probe, corner_hit;
  logic [COORD_BITS-1:0] ld_x, ld_y, ld_z;

  function automatic logic signed [31:0] midpoint(input logic [COORD_BITS-1:0] u,
                                                  input logic [COORD_BITS-1:0] v);
    logic signed [COORD_BITS:0] s;
    s = $signed({u[COORD_BITS-1], u}) + $signed({v[COORD_BITS-1], v});
    s = s >>> 1;
    return 32'(s);
  endfunction

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign clr_end = clr_r == CLR_W'(CLR_N - 1);
  assign is_edge = slot_is_edge(slot_r);
  assign k_done  = k_r == '0;

  // Node selection for the current slot
  always_comb begin
    case (slot_r)
      SLOT_C0: cn = a_r;
      SLOT_C1: cn = b_r;
      default: cn = c_r;
    endcase
    pn = ((slot_r == SLOT_M01) || (slot_r == SLOT_M02)) ? a_r : b_r;
    qn = (slot_r == SLOT_M01) ? b_r : c_r;
    lo_n = (pn < qn) ? pn : qn;
    hi_n = (pn < qn) ? qn : pn;
    hash_n = (HASH_W'(lo_n) << 5) - HASH_W'(lo_n) + HASH_W'(hi_n);
  end

  // Shared remainder unit: k=2 multiply by reciprocal, k=1 subtract
  // quotient times divisor, k=0 one final compare and subtract
  always_comb begin
    div_sel  = (state_r == S_HASH) ? DIV_W'(MAX_EDGES) : DIV_W'(MAX_NODES);
    rcp_sel  = (state_r == S_HASH) ? MB_W'(RCP_E) : MB_W'(RCP_N);
    q_w      = prod_r[REM_W +: REM_W];
    mul_a    = (k_r == K_W'(2)) ? rem_r : q_w;
    mul_b    = (k_r == K_W'(2)) ? rcp_sel : MB_W'(div_sel);
    mul_p    = MUL_W'(mul_a) * MUL_W'(mul_b);
    case (k_r)
      K_W'(2): rem_step = rem_r;
      K_W'(1): rem_step = rem_r - REM_W'(mul_p);
      default: rem_step = (SH_W'(rem_r) >= SH_W'(div_sel)) ? (rem_r - REM_W'(div_sel))
                                                            : rem_r;
    endcase
  end

  // Edge table compare
  assign hit        = ek_rd == {1'b1, lo_r, hi_r};
  assign empty      = !ek_rd[KEY_W-1];
  assign last_probe = pcnt_r == EDGE_W'(MAX_EDGES - 1);
  assign corner_hit = cm_rd[LABEL_W];

  // Loaded coordinates keep the low bits, sign-extended to storage width
  assign ld_x = COORD_BITS'($signed(cx_r[LOAD_W-1:0]));
  assign ld_y = COORD_BITS'($signed(cy_r[LOAD_W-1:0]));
  assign ld_z = COORD_BITS'($signed(cz_r[LOAD_W-1:0]));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_end) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.command)
            CMD_CLEAR:  state_nxt = S_CLEAR;
            CMD_LOAD:   state_nxt = NODE_MOD ? S_REDUCE : S_LOAD;
            CMD_REFINE: state_nxt = NODE_MOD ? S_REDUCE : S_SLOT;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_REDUCE: begin
        if (k_done && (cmd_r == CMD_LOAD)) state_nxt = S_LOAD;
        else if (k_done && (red_r == 2'd2)) state_nxt = S_SLOT;
      end
      S_LOAD:     state_nxt = S_IDLE;
      S_SLOT:     state_nxt = is_edge ? S_EDGE_P : S_CORNER;
      S_CORNER:   state_nxt = S_EMIT;
      S_EDGE_P:   state_nxt = S_EDGE_Q;
      S_EDGE_Q:   state_nxt = EDGE_POW2 ? S_PROBE_RD : S_HASH;
      S_HASH: begin
        if (k_done) state_nxt = S_PROBE_RD;
      end
      S_PROBE_RD: state_nxt = S_PROBE;
      S_PROBE: begin
        if (hit || empty || last_probe) state_nxt = S_EMIT;
        else state_nxt = S_PROBE_RD;
      end
      S_EMIT: begin
        if (out_acc) state_nxt = (slot_r == SLOT_C2) ? S_IDLE : S_SLOT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and memory controls
  always_comb begin
    in_ch.ready = state_r == S_IDLE;
    crd_we      = state_r == S_LOAD;
    node_raddr  = (state_r == S_EDGE_P) ? qn : (is_edge ? pn : cn);
    cm_we       = 1'b0;
    cm_waddr    = cn;
    cm_wdata    = {1'b1, next_label_r};
    ek_we       = 1'b0;
    ek_waddr    = idx_r;
    ek_wdata    = {1'b1, lo_r, hi_r};
    el_we       = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cm_we    = {1'b0, clr_r} < (CLR_W + 1)'(MAX_NODES);
        cm_waddr = NODE_W'(clr_r);
        cm_wdata = '0;
        ek_we    = {1'b0, clr_r} < (CLR_W + 1)'(MAX_EDGES);
        ek_waddr = EDGE_W'(clr_r);
        ek_wdata = '0;
      end
      S_CORNER: cm_we = !corner_hit;
      S_PROBE: begin
        ek_we = empty;
        el_we = empty;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      next_label_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + CLR_W'(1);
      if (in_acc && (in_ch.command == CMD_CLEAR)) begin
        clr_r        <= '0;
        next_label_r <= '0;
      end
      if ((state_r == S_CORNER && !corner_hit) || (state_r == S_PROBE && !hit && empty)) begin
        next_label_r <= next_label_r + LABEL_W'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cmd_r  <= in_ch.command;
        vb_r   <= in_ch.vertex_b;
        vc_r   <= in_ch.vertex_c;
        cx_r   <= in_ch.coord_x;
        cy_r   <= in_ch.coord_y;
        cz_r   <= in_ch.coord_z;
        a_r    <= NODE_W'(in_ch.vertex_a);
        b_r    <= NODE_W'(in_ch.vertex_b);
        c_r    <= NODE_W'(in_ch.vertex_c);
        red_r  <= 2'd0;
        rem_r  <= REM_W'(in_ch.vertex_a);
        k_r    <= K_W'(2);
        slot_r <= SLOT_C0;
      end
      S_REDUCE: begin
        prod_r <= mul_p;
        if (k_done) begin
          case (red_r)
            2'd0: begin
              a_r   <= NODE_W'(rem_step);
              rem_r <= REM_W'(vb_r);
            end
            2'd1: begin
              b_r   <= NODE_W'(rem_step);
              rem_r <= REM_W'(vc_r);
            end
            default: c_r <= NODE_W'(rem_step);
          endcase
          red_r <= red_r + 2'd1;
          k_r   <= K_W'(2);
        end else begin
          rem_r <= rem_step;
          k_r   <= k_r - K_W'(1);
        end
      end
      S_SLOT: pcnt_r <= '0;
      S_CORNER: begin
        o_label_r <= corner_hit ? cm_rd[LABEL_W-1:0] : next_label_r;
        o_new_r   <= !corner_hit;
        o_full_r  <= 1'b0;
        o_x_r     <= 32'($signed(xr));
        o_y_r     <= 32'($signed(yr));
        o_z_r     <= 32'($signed(zr));
      end
      S_EDGE_P: begin
        px_r <= xr;
        py_r <= yr;
        pz_r <= zr;
      end
      S_EDGE_Q: begin
        o_x_r <= midpoint(px_r, xr);
        o_y_r <= midpoint(py_r, yr);
        o_z_r <= midpoint(pz_r, zr);
        lo_r  <= lo_n;
        hi_r  <= hi_n;
        idx_r <= EDGE_W'(hash_n);
        rem_r <= REM_W'(hash_n);
        k_r   <= K_W'(2);
      end
      S_HASH: begin
        prod_r <= mul_p;
        if (k_done) begin
          idx_r <= EDGE_W'(rem_step);
        end else begin
          rem_r <= rem_step;
          k_r   <= k_r - K_W'(1);
        end
      end
      S_PROBE: begin
        if (hit) begin
          o_label_r <= el_rd;
          o_new_r   <= 1'b0;
          o_full_r  <= 1'b0;
        end else if (empty) begin
          o_label_r <= next_label_r;
          o_new_r   <= 1'b1;
          o_full_r  <= 1'b0;
        end else if (last_probe) begin
          o_label_r <= '0;
          o_new_r   <= 1'b0;
          o_full_r  <= 1'b1;
        end else begin
          idx_r  <= (idx_r == EDGE_W'(MAX_EDGES - 1)) ? '0 : idx_r + EDGE_W'(1);
          pcnt_r <= pcnt_r + EDGE_W'(1);
        end
      end
      S_EMIT: begin
        if (out_acc && (slot_r != SLOT_C2)) slot_r <= slot_r + SLOT_W'(1);
      end
      default: ;
    endcase
  end

  // Node coordinate stores
  p2rl_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_NODES)) u_x_ram (
    .clk(clk), .we(crd_we), .waddr(a_r), .wdata(ld_x), .raddr(node_raddr), .rdata(xr)
  );
  p2rl_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_NODES)) u_y_ram (
    .clk(clk), .we(crd_we), .waddr(a_r), .wdata(ld_y), .raddr(node_raddr), .rdata(yr)
  );
  p2rl_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_NODES)) u_z_ram (
    .clk(clk), .we(crd_we), .waddr(a_r), .wdata(ld_z), .raddr(node_raddr), .rdata(zr)
  );

  // Corner label map: assigned flag over label
  p2rl_ram #(.WIDTH(CMAP_W), .DEPTH(MAX_NODES)) u_cmap_ram (
    .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata), .raddr(node_raddr),
    .rdata(cm_rd)
  );

  // Edge table: keys and labels
  p2rl_ram #(.WIDTH(KEY_W), .DEPTH(MAX_EDGES)) u_ekey_ram (
    .clk(clk), .we(ek_we), .waddr(ek_waddr), .wdata(ek_wdata), .raddr(idx_r),
    .rdata(ek_rd)
  );
  p2rl_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_EDGES)) u_elab_ram (
    .clk(clk), .we(el_we), .waddr(idx_r), .wdata(next_label_r), .raddr(idx_r),
    .rdata(el_rd)
  );

  // Result channel
  assign out_ch.valid      = state_r == S_EMIT;
  assign out_ch.slot       = slot_r;
  assign out_ch.label      = o_label_r;
  assign out_ch.is_new     = o_new_r;
  assign out_ch.out_x      = o_x_r;
  assign out_ch.out_y      = o_y_r;
  assign out_ch.out_z      = o_z_r;
  assign out_ch.table_full = o_full_r;
  assign out_ch.last       = slot_r == SLOT_C2;

  // Checks
  a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input accepted while a result is pending");

  a_full_no_label: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.table_full |-> out_ch.label == '0 && !out_ch.is_new)
    else $error("full edge table result carries a label");

  a_new_label_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_new |-> next_label_r == out_ch.label + LABEL_W'(1))
    else $error("new label not taken from the counter");

endmodule
